>>> src/lrc_pkg.sv
// Shared types and constants for the line row clusterer.
// No dependencies; every other file uses this package.
`default_nettype none

package lrc_pkg;

  localparam int MAX_LINES_DEF  = 64;
  localparam int COORD_BITS_DEF = 11;
  localparam int DIST_BITS      = 11;
  localparam logic [DIST_BITS-1:0] MERGE_RESET = 11'd10;

  typedef enum logic [0:0] {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } lrc_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the new record in sorted position
    logic shift;  // move every record one cell toward the head
  } lrc_ctrl_t;

  // Status from the merge unit back to the sequencer.
  typedef struct packed {
    logic shift;  // head record consumed this cycle
    logic done;   // final cluster issued, set complete
  } lrc_mstat_t;

endpackage

`default_nettype wire

>>> src/lrc_if.sv
// Valid/ready channel interfaces: line input, cluster output, configuration write.
// Depends on lrc_pkg.
`default_nettype none

interface lrc_line_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic                  last_line;

  modport source (output valid, start_x, start_y, end_x, end_y, last_line, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, last_line, output ready);
endinterface

interface lrc_cluster_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cluster_center_x;
  logic [COORD_BITS-1:0] cluster_center_y;
  logic [COORD_BITS-1:0] cluster_left;
  logic [COORD_BITS-1:0] cluster_right;
  logic                  last_cluster;
  logic                  lines_dropped;

  modport source (output valid, cluster_center_x, cluster_center_y, cluster_left,
                  cluster_right, last_cluster, lines_dropped, input ready);
  modport sink   (input valid, cluster_center_x, cluster_center_y, cluster_left,
                  cluster_right, last_cluster, lines_dropped, output ready);
endinterface

interface lrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lrc_pkg::DIST_BITS-1:0] merge_distance;

  modport source (output valid, merge_distance, input ready);
  modport sink   (input valid, merge_distance, output ready);
endinterface

`default_nettype wire

>>> src/lrc_cell.sv
// One cell of the sorted record chain: holds one record and its valid bit.
// Depends on lrc_pkg.
`default_nettype none

module lrc_cell #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrc_pkg::lrc_ctrl_t    ctrl,
  input  logic [COORD_BITS-1:0] new_lx,
  input  logic [COORD_BITS-1:0] new_rx,
  input  logic [COORD_BITS-1:0] new_cy,
  input  logic [COORD_BITS-1:0] prev_lx,
  input  logic [COORD_BITS-1:0] prev_rx,
  input  logic [COORD_BITS-1:0] prev_cy,
  input  logic                  prev_valid,
  input  logic                  prev_yield,
  input  logic [COORD_BITS-1:0] next_lx,
  input  logic [COORD_BITS-1:0] next_rx,
  input  logic [COORD_BITS-1:0] next_cy,
  input  logic                  next_valid,
  output logic [COORD_BITS-1:0] lx,
  output logic [COORD_BITS-1:0] rx,
  output logic [COORD_BITS-1:0] cy,
  output logic                  valid,
  output logic                  yield
);
  import lrc_pkg::*;

  // Strictly-less keeps a new record behind stored ones of equal center y.
  assign yield = !valid || (cy < new_cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.ins && yield) begin
      valid <= prev_yield ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      lx <= next_lx;
      rx <= next_rx;
      cy <= next_cy;
    end else if (ctrl.ins && yield) begin
      if (prev_yield) begin
        lx <= prev_lx;
        rx <= prev_rx;
        cy <= prev_cy;
      end else begin
        lx <= new_lx;
        rx <= new_rx;
        cy <= new_cy;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lrc_chain.sv
// Row of lrc_cell instances kept sorted by descending center y; cell 0 is the head.
// Depends on lrc_pkg and lrc_cell.
`default_nettype none

module lrc_chain #(
  parameter int MAX_LINES  = lrc_pkg::MAX_LINES_DEF,
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrc_pkg::lrc_ctrl_t    ctrl,
  input  logic [COORD_BITS-1:0] new_lx,
  input  logic [COORD_BITS-1:0] new_rx,
  input  logic [COORD_BITS-1:0] new_cy,
  output logic [COORD_BITS-1:0] head_lx,
  output logic [COORD_BITS-1:0] head_rx,
  output logic [COORD_BITS-1:0] head_cy,
  output logic                  head_valid,
  output logic                  full
);
  import lrc_pkg::*;

  // Index MAX_LINES is a permanently empty slot past the tail.
  logic [COORD_BITS-1:0] c_lx    [MAX_LINES+1];
  logic [COORD_BITS-1:0] c_rx    [MAX_LINES+1];
  logic [COORD_BITS-1:0] c_cy    [MAX_LINES+1];
  logic                  c_valid [MAX_LINES+1];
  logic                  c_yield [MAX_LINES];

  assign c_lx[MAX_LINES]    = '0;
  assign c_rx[MAX_LINES]    = '0;
  assign c_cy[MAX_LINES]    = '0;
  assign c_valid[MAX_LINES] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_LINES; g++) begin : g_cell
      if (g == 0) begin : g_head
        lrc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
          .clk, .rst, .ctrl, .new_lx, .new_rx, .new_cy,
          .prev_lx('0), .prev_rx('0), .prev_cy('0),
          .prev_valid(1'b0), .prev_yield(1'b0),
          .next_lx(c_lx[g+1]), .next_rx(c_rx[g+1]), .next_cy(c_cy[g+1]),
          .next_valid(c_valid[g+1]),
          .lx(c_lx[g]), .rx(c_rx[g]), .cy(c_cy[g]), .valid(c_valid[g]),
          .yield(c_yield[g])
        );
      end else begin : g_body
        lrc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
          .clk, .rst, .ctrl, .new_lx, .new_rx, .new_cy,
          .prev_lx(c_lx[g-1]), .prev_rx(c_rx[g-1]), .prev_cy(c_cy[g-1]),
          .prev_valid(c_valid[g-1]), .prev_yield(c_yield[g-1]),
          .next_lx(c_lx[g+1]), .next_rx(c_rx[g+1]), .next_cy(c_cy[g+1]),
          .next_valid(c_valid[g+1]),
          .lx(c_lx[g]), .rx(c_rx[g]), .cy(c_cy[g]), .valid(c_valid[g]),
          .yield(c_yield[g])
        );
      end
    end
  endgenerate

  assign head_lx    = c_lx[0];
  assign head_rx    = c_rx[0];
  assign head_cy    = c_cy[0];
  assign head_valid = c_valid[0];
  assign full       = c_valid[MAX_LINES-1];

endmodule

`default_nettype wire

>>> src/lrc_merge.sv
// Cluster accumulator and output register: consumes the chain head while draining.
// Depends on lrc_pkg and lrc_if.
`default_nettype none

module lrc_merge #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          draining,
  input  logic [COORD_BITS-1:0]         head_lx,
  input  logic [COORD_BITS-1:0]         head_rx,
  input  logic [COORD_BITS-1:0]         head_cy,
  input  logic                          head_valid,
  input  logic [lrc_pkg::DIST_BITS-1:0] merge_distance,
  input  logic                          overflow,
  output lrc_pkg::lrc_mstat_t           mstat,
  lrc_cluster_if.source                 cluster_out
);
  import lrc_pkg::*;

  localparam int CMP_BITS = (COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS;

  logic                  have_cur;
  logic [COORD_BITS-1:0] cur_lx;
  logic [COORD_BITS-1:0] cur_rx;
  logic [COORD_BITS-1:0] cur_cy;
  logic                  out_valid;

  logic [COORD_BITS-1:0] y_gap;
  logic                  near;
  logic                  slot_free;
  logic                  take;
  logic                  merge;
  logic                  emit;
  logic                  emit_last;
  logic [COORD_BITS:0]   y_sum;
  logic [COORD_BITS:0]   x_sum;

  assign y_gap = (cur_cy >= head_cy) ? (cur_cy - head_cy) : (head_cy - cur_cy);
  assign near  = CMP_BITS'(y_gap) < CMP_BITS'(merge_distance);
  assign y_sum = {1'b0, cur_cy} + {1'b0, head_cy};
  assign x_sum = {1'b0, cur_lx} + {1'b0, cur_rx};
  assign slot_free = !out_valid || cluster_out.ready;

  always_comb begin
    take      = 1'b0;
    merge     = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    if (draining) begin
      priority if (!have_cur) begin
        take = head_valid;
      end else if (head_valid) begin
        if (near) begin
          merge = 1'b1;
        end else if (slot_free) begin
          emit = 1'b1;
          take = 1'b1;
        end
      end else if (slot_free) begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
    end
  end

  assign mstat.shift = take || merge;
  assign mstat.done  = emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_cur  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        have_cur <= 1'b1;
      end else if (emit_last) begin
        have_cur <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (cluster_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_lx <= head_lx;
      cur_rx <= head_rx;
      cur_cy <= head_cy;
    end else if (merge) begin
      cur_cy <= y_sum[COORD_BITS:1];
      if (head_lx < cur_lx) begin
        cur_lx <= head_lx;
      end
      if (head_rx > cur_rx) begin
        cur_rx <= head_rx;
      end
    end
    if (emit) begin
      cluster_out.cluster_center_x <= x_sum[COORD_BITS:1];
      cluster_out.cluster_center_y <= cur_cy;
      cluster_out.cluster_left     <= cur_lx;
      cluster_out.cluster_right    <= cur_rx;
      cluster_out.last_cluster     <= emit_last;
      cluster_out.lines_dropped    <= overflow;
    end
  end

  assign cluster_out.valid = out_valid;

endmodule

`default_nettype wire

>>> src/line_row_clusterer.sv
// Top level of the line row clusterer: sequencer, config register, chain, merge unit.
// Depends on lrc_pkg, lrc_if, lrc_chain and lrc_merge.
//
//   channel   | dir | transfer
//   ----------+-----+--------------------------------------------------
//   lines     | in  | one segment per transaction, last_line ends a set
//   clusters  | out | one cluster per transaction, last_cluster on final
//   cfg       | in  | merge_distance write, always ready
//
// Loading takes one segment per cycle; the insertion chain stores it in sorted position
// at the edge that accepts it. After the last segment the chain drains through the merge
// unit, one record per cycle while the output register is not stalled. Segments are
// not accepted while draining. Reset clears valid bits and flags at once; no clearing
// pass. Output holds in its register until taken.
`default_nettype none

module line_row_clusterer #(
  parameter int MAX_LINES  = lrc_pkg::MAX_LINES_DEF,
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lrc_line_if.sink      lines,
  lrc_cluster_if.source clusters,
  lrc_cfg_if.sink       cfg
);
  import lrc_pkg::*;

  lrc_state_t state;
  lrc_state_t state_next;
  logic [DIST_BITS-1:0] merge_distance;
  logic                 overflow;

  logic                  accept;
  logic                  full;
  lrc_ctrl_t             ctrl;
  lrc_mstat_t            mstat;
  logic [COORD_BITS:0]   y_sum;
  logic [COORD_BITS-1:0] head_lx;
  logic [COORD_BITS-1:0] head_rx;
  logic [COORD_BITS-1:0] head_cy;
  logic                  head_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_distance <= MERGE_RESET;
    end else if (cfg.valid) begin
      merge_distance <= cfg.merge_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    lines.ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        lines.ready = 1'b1;
        if (lines.valid && lines.last_line) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mstat.done) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign accept     = lines.valid && lines.ready;
  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = mstat.shift;
  assign y_sum      = {1'b0, lines.start_y} + {1'b0, lines.end_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow <= 1'b0;
    end else if (accept && full) begin
      overflow <= 1'b1;
    end else if (mstat.done) begin
      overflow <= 1'b0;
    end
  end

  lrc_chain #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) u_chain (
    .clk, .rst, .ctrl,
    .new_lx(lines.start_x), .new_rx(lines.end_x), .new_cy(y_sum[COORD_BITS:1]),
    .head_lx, .head_rx, .head_cy, .head_valid, .full
  );

  lrc_merge #(.COORD_BITS(COORD_BITS)) u_merge (
    .clk, .rst,
    .draining(state == ST_DRAIN),
    .head_lx, .head_rx, .head_cy, .head_valid,
    .merge_distance, .overflow, .mstat,
    .cluster_out(clusters)
  );

  a_no_shift_in_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> !mstat.shift)
    else $error("chain shifted while loading");

  a_done_issues_last: assert property (@(posedge clk) disable iff (rst)
    mstat.done |=> state == ST_LOAD && !overflow && clusters.valid && clusters.last_cluster)
    else $error("set completion did not present the last cluster");

  a_drop_sets_flag: assert property (@(posedge clk) disable iff (rst)
    accept && full |=> overflow)
    else $error("dropped segment did not raise overflow");

  a_drain_not_empty: assert property (@(posedge clk) disable iff (rst)
    accept && lines.last_line |=> head_valid)
    else $error("drain started with an empty chain");

endmodule

`default_nettype wire

>>> bench/tb_line_row_clusterer.sv
`timescale 1ns / 1ps
// Testbench for line_row_clusterer: directed and random segment sets, checked by a scoreboard.
// Depends on lrc_pkg, the channel interfaces in lrc_if and the line_row_clusterer top level.

module tb_line_row_clusterer;
  import lrc_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int CAP      = MAX_LINES_DEF;
  localparam int IDLE_PCT = 19;
  localparam int SEG_GOAL = 470;

  typedef logic [CB-1:0]        coord_t;
  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   last;
  } segment_t;

  typedef struct packed {
    coord_t lx;
    coord_t rx;
    coord_t cx;
    coord_t cy;
  } row_rec_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t lx;
    coord_t rx;
    logic   last;
    logic   dropped;
  } cluster_t;

  // Row grouping predictor plus the queue of clusters still owed by the block.
  class row_scoreboard;
    dist_t    merge_distance = MERGE_RESET;
    row_rec_t sorted_segs[$];
    bit       overflow_seen;
    cluster_t pending_clusters[$];
    int       mismatches;
    int       checked;
    int       overflow_sets;

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    function void close_cluster(row_rec_t c, bit last);
      pending_clusters.insert(pending_clusters.size(),
                              cluster_t'{c.cx, c.cy, c.lx, c.rx, last, overflow_seen});
    endfunction

    function void note_segment(segment_t s);
      row_rec_t    r;
      row_rec_t    cur;
      row_rec_t    nxt;
      logic [CB:0] sum;
      coord_t      d;
      int          pos;
      r.lx = s.sx;
      r.rx = s.ex;
      sum  = s.sx + s.ex;
      r.cx = sum[CB:1];
      sum  = s.sy + s.ey;
      r.cy = sum[CB:1];
      if (sorted_segs.size() < CAP) begin
        // equal center y goes after the records already stored
        pos = sorted_segs.size();
        while (pos > 0 && sorted_segs[pos-1].cy < r.cy) pos--;
        sorted_segs.insert(pos, r);
      end else begin
        overflow_seen = 1'b1;
      end
      if (!s.last) return;
      if (overflow_seen) overflow_sets++;
      cur = sorted_segs[0];
      for (int i = 1; i < sorted_segs.size(); i++) begin
        nxt = sorted_segs[i];
        d = (cur.cy >= nxt.cy) ? cur.cy - nxt.cy : nxt.cy - cur.cy;
        if (d < merge_distance) begin
          sum    = cur.cy + nxt.cy;
          cur.cy = sum[CB:1];
          if (nxt.lx < cur.lx) cur.lx = nxt.lx;
          if (nxt.rx > cur.rx) cur.rx = nxt.rx;
          sum    = cur.lx + cur.rx;
          cur.cx = sum[CB:1];
        end else begin
          close_cluster(cur, 1'b0);
          cur = nxt;
        end
      end
      close_cluster(cur, 1'b1);
      sorted_segs.delete();
      overflow_seen = 1'b0;
    endfunction

    task check_cluster(cluster_t got);
      cluster_t want;
      string    names[6] = '{"center_x", "center_y", "left", "right",
                             "last_cluster", "lines_dropped"};
      int       gv[6];
      int       wv[6];
      if (pending_clusters.size() == 0) begin
        report_mismatch($sformatf("cluster cx=%0d cy=%0d l=%0d r=%0d with none predicted",
                                  got.cx, got.cy, got.lx, got.rx));
        return;
      end
      want = pending_clusters.pop_front();
      gv = '{got.cx, got.cy, got.lx, got.rx, got.last, got.dropped};
      wv = '{want.cx, want.cy, want.lx, want.rx, want.last, want.dropped};
      for (int i = 0; i < 6; i++)
        if (gv[i] != wv[i])
          report_mismatch($sformatf("cluster %0d %s got %0d, want %0d",
                                    checked, names[i], gv[i], wv[i]));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;

  lrc_line_if    lines_if ();
  lrc_cluster_if clus_if ();
  lrc_cfg_if     cfg_if ();

  line_row_clusterer uut (
    .clk      (clk),
    .rst      (rst),
    .lines    (lines_if),
    .clusters (clus_if),
    .cfg      (cfg_if)
  );

  row_scoreboard sb = new;
  bit            calm;
  int            segs_sent;
  int            sets_done;
  int            dist_writes;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // cluster sink: random backpressure unless calm, check on every transaction
  always @(posedge clk) begin
    if (rst) begin
      clus_if.ready <= 1'b0;
    end else begin
      if (clus_if.valid && clus_if.ready)
        sb.check_cluster(cluster_t'{clus_if.cluster_center_x, clus_if.cluster_center_y,
                                    clus_if.cluster_left, clus_if.cluster_right,
                                    clus_if.last_cluster, clus_if.lines_dropped});
      clus_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic coord_t near_row(int row, int jit);
    int v;
    v = row + int'($urandom_range(2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return coord_t'(v);
  endfunction

  task automatic send_segment(segment_t s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      lines_if.valid <= 1'b0;
      @(posedge clk);
    end
    lines_if.valid     <= 1'b1;
    lines_if.start_x   <= s.sx;
    lines_if.start_y   <= s.sy;
    lines_if.end_x     <= s.ex;
    lines_if.end_y     <= s.ey;
    lines_if.last_line <= s.last;
    @(posedge clk);
    while (!lines_if.ready) @(posedge clk);
    sb.note_segment(s);
    segs_sent++;
    if (s.last) sets_done++;
  endtask

  // hold the sender until every cluster is in, then let the drain finish
  task automatic wait_drained();
    lines_if.valid <= 1'b0;
    while (sb.pending_clusters.size() != 0) @(posedge clk);
    repeat (CAP + 4) @(posedge clk);
  endtask

  task automatic write_distance(dist_t v);
    wait_drained();
    cfg_if.valid          <= 1'b1;
    cfg_if.merge_distance <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid   <= 1'b0;
    sb.merge_distance = v;
    dist_writes++;
  endtask

  // rows of nearby center y with a share of stray segments anywhere
  task automatic send_set(int n);
    int       rows[4];
    int       nrows;
    int       jit;
    int       r;
    segment_t s;
    nrows = $urandom_range(1, 4);
    for (int i = 0; i < nrows; i++) rows[i] = $urandom_range(2047);
    jit = (sb.merge_distance == 0) ? 8 : (sb.merge_distance > 200 ? 200 : sb.merge_distance);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(nrows - 1);
      s.sx = coord_t'($urandom_range(2047));
      s.ex = ($urandom_range(3) == 0) ? coord_t'($urandom_range(2047)) : near_row(s.sx, 300);
      if ($urandom_range(9) < 2) begin
        s.sy = coord_t'($urandom_range(2047));
        s.ey = coord_t'($urandom_range(2047));
      end else begin
        s.sy = near_row(rows[r], jit);
        s.ey = near_row(rows[r], jit);
      end
      s.last = (i == n - 1);
      send_segment(s);
    end
  endtask

  initial begin
    dist_t picks[7] = '{0, 1, 2047, MERGE_RESET, 3, 40, 500};
    int    k;
    int    n;
    int    set_no;
    rst                   = 1'b1;
    lines_if.valid        = 1'b0;
    lines_if.start_x      = '0;
    lines_if.start_y      = '0;
    lines_if.end_x        = '0;
    lines_if.end_y        = '0;
    lines_if.last_line    = 1'b0;
    clus_if.ready         = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.merge_distance = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset distance: extremes, left right of right, near rows, equal center y
    send_segment(segment_t'{11'd0, 11'd0, 11'd0, 11'd0, 1'b0});
    send_segment(segment_t'{11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0});
    send_segment(segment_t'{11'd2047, 11'd0, 11'd0, 11'd2047, 1'b0});
    send_segment(segment_t'{11'd100, 11'd1020, 11'd300, 11'd1030, 1'b0});
    send_segment(segment_t'{11'd50, 11'd1010, 11'd60, 11'd1012, 1'b0});
    send_segment(segment_t'{11'd500, 11'd1011, 11'd510, 11'd1011, 1'b0});
    send_segment(segment_t'{11'd1, 11'd2046, 11'd2046, 11'd2047, 1'b0});
    send_segment(segment_t'{11'd1024, 11'd5, 11'd1023, 11'd4, 1'b1});
    // a set of one segment
    send_segment(segment_t'{11'd2047, 11'd2047, 11'd0, 11'd0, 1'b1});

    // zero distance: nothing merges, equal center y included
    write_distance(dist_t'(0));
    send_segment(segment_t'{11'd10, 11'd10, 11'd20, 11'd10, 1'b0});
    send_segment(segment_t'{11'd30, 11'd10, 11'd40, 11'd10, 1'b0});
    send_segment(segment_t'{11'd0, 11'd2047, 11'd2047, 11'd0, 1'b0});
    send_segment(segment_t'{11'd5, 11'd6, 11'd7, 11'd8, 1'b1});

    // widest distance: everything merges except a full-height gap
    write_distance(dist_t'(2047));
    send_segment(segment_t'{11'd0, 11'd0, 11'd0, 11'd0, 1'b0});
    send_segment(segment_t'{11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0});
    send_segment(segment_t'{11'd3, 11'd1000, 11'd4, 11'd1000, 1'b1});
    send_segment(segment_t'{11'd0, 11'd0, 11'd9, 11'd0, 1'b0});
    send_segment(segment_t'{11'd2047, 11'd2047, 11'd12, 11'd2047, 1'b1});

    // distance one: a gap of one splits, equal y merges
    write_distance(dist_t'(1));
    send_segment(segment_t'{11'd0, 11'd100, 11'd0, 11'd100, 1'b0});
    send_segment(segment_t'{11'd0, 11'd101, 11'd0, 11'd101, 1'b0});
    send_segment(segment_t'{11'd7, 11'd100, 11'd9, 11'd100, 1'b1});

    // capacity: the last segment of this set is the one dropped
    write_distance(MERGE_RESET);
    send_set(CAP + 1);

    set_no = 0;
    while (segs_sent < SEG_GOAL) begin
      calm = (set_no >= 12 && set_no < 20);
      if (set_no % 3 == 2) begin
        k = $urandom_range(7);
        write_distance((k == 7) ? dist_t'($urandom_range(2047)) : picks[k]);
      end else if ($urandom_range(4) == 0) begin
        wait_drained();
      end
      k = $urandom_range(99);
      if (k < 5)       n = $urandom_range(CAP, CAP + 8);
      else if (k < 15) n = $urandom_range(20, 40);
      else             n = $urandom_range(1, 10);
      send_set(n);
      set_no++;
    end
    calm = 1'b0;

    lines_if.valid <= 1'b0;
    while (sb.pending_clusters.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    $display("Sent %0d segments in %0d sets over %0d distance settings; %0d clusters checked.",
             segs_sent, sets_done, dist_writes + 1, sb.checked);
    $display("%0d sets went over capacity; %0d mismatches.", sb.overflow_sets, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_clusters.size() == 0) begin
      $display("line_row_clusterer test passed");
    end else begin
      $display("line_row_clusterer test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d clusters outstanding", sb.pending_clusters.size());
    $display("line_row_clusterer test failed");
    $finish;
  end

endmodule

>>> filelist.f
src/lrc_pkg.sv
src/lrc_if.sv
src/lrc_cell.sv
src/lrc_chain.sv
src/lrc_merge.sv
src/line_row_clusterer.sv
bench/tb_line_row_clusterer.sv
